// File: hdl/bprs_pkg.sv
// ----------------------------------------------------------------------------
// bprs_pkg: shared types and constants for the block partition range splitter
// Field widths, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package bprs_pkg;

  localparam int FIELD_W      = 31;   // row fields on the channels
  localparam int OWNER_W      = 6;    // owner field on the result channel
  localparam int PCOUNT_W     = 7;    // proc_count register
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 31;

  localparam int DEF_MAX_OWNERS = 64;
  localparam int DEF_ROW_BITS   = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TOTAL_ROWS = 1'b0;
  localparam cfg_idx_t REG_PROC_COUNT = 1'b1;

  typedef logic [FIELD_W-1:0] row_field_t;
  typedef logic [OWNER_W-1:0] owner_t;

endpackage

// File: hdl/bprs_in_if.sv
// ----------------------------------------------------------------------------
// bprs_in_if: range request channel
// Valid/ready channel carrying one inclusive row range per request.
// ----------------------------------------------------------------------------
interface bprs_in_if import bprs_pkg::*; ();
  logic       valid;
  logic       ready;
  row_field_t range_first;
  row_field_t range_last;

  modport source (output valid, output range_first, output range_last, input ready);
  modport sink   (input valid, input range_first, input range_last, output ready);
endinterface

// File: hdl/bprs_out_if.sv
// ----------------------------------------------------------------------------
// bprs_out_if: piece result channel
// Valid/ready channel carrying one owner piece per transfer.
// ----------------------------------------------------------------------------
interface bprs_out_if import bprs_pkg::*; ();
  logic       valid;
  logic       ready;
  owner_t     owner;
  row_field_t piece_first;
  row_field_t piece_last;
  logic       is_last;
  logic       empty_res;

  modport source (output valid, output owner, output piece_first, output piece_last,
                  output is_last, output empty_res, input ready);
  modport sink   (input valid, input owner, input piece_first, input piece_last,
                  input is_last, input empty_res, output ready);
endinterface

// File: hdl/block_partition_range_splitter_top.sv
// ----------------------------------------------------------------------------
// block_partition_range_splitter_top: split a row range over block owners
// Finds the owners of the first and last row of a range in a balanced block
// distribution and emits one clipped piece per owner in between.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_idx/cfg_wdata write total_rows (index 0) and proc_count
//   (index 1); write only while the block is idle.
//   in_ch takes one range request when valid and ready are high. ready is
//   high only while the block is idle, so one range is worked at a time.
//   out_ch returns the pieces in ascending owner order, the final one with
//   is_last set; an empty range (first > last) gives one result with
//   empty_res set and all other fields zero.
// Sequence: one restoring divider (one quotient bit per cycle) runs for
//   total_rows / proc_count and for the owners of the first and last row,
//   except a row past a distribution with no full blocks, which needs no
//   division; the base steps then compute the block start before the first
//   piece is registered. An empty range goes straight to the empty result,
//   loaded once the output is free. Then one piece per cycle while ready.
// The next range is accepted as soon as the final piece sits in the output
//   register. A stalled receiver holds the output register and the piece
//   sequencer until ready returns; nothing is dropped.
// Reset: rst_n (synchronous) returns to idle, drops the output valid and
//   loads total_rows = 64, proc_count = 1.
// ----------------------------------------------------------------------------
module block_partition_range_splitter_top import bprs_pkg::*; #(
  parameter int MAX_OWNERS = DEF_MAX_OWNERS,
  parameter int ROW_BITS   = DEF_ROW_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bprs_in_if.sink               in_ch,
  bprs_out_if.source            out_ch
);

  localparam int CNT_W = $clog2(ROW_BITS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVN  = 4'd1;
  localparam logic [3:0] S_SW    = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DIVR  = 4'd4;
  localparam logic [3:0] S_BASE1 = 4'd5;
  localparam logic [3:0] S_BASE2 = 4'd6;
  localparam logic [3:0] S_BASE3 = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_EMPTY = 4'd9;

  // configuration
  logic [ROW_BITS-1:0] total_rows_r;
  logic [PCOUNT_W-1:0] proc_count_r;

  logic [3:0]          state_r;

  // held range
  logic [ROW_BITS-1:0] first_r;
  logic [ROW_BITS-1:0] last_r;

  // distribution geometry
  logic [ROW_BITS-1:0] size_r;
  logic [PCOUNT_W-1:0] extra_r;
  logic [ROW_BITS:0]   sw_r;
  logic [OWNER_W-1:0]  cap_r;

  // shared serial divider
  logic [ROW_BITS-1:0] div_dvd_r;
  logic [ROW_BITS:0]   div_dvs_r;
  logic [ROW_BITS:0]   div_rem_r;
  logic [ROW_BITS-1:0] div_q_r;
  logic [CNT_W-1:0]    div_cnt_r;
  logic [ROW_BITS+1:0] div_trial;
  logic                div_ge;
  logic [ROW_BITS:0]   div_rem_nxt;
  logic [ROW_BITS-1:0] div_q_nxt;

  logic                which_r;     // 0: first row, 1: last row
  logic                add_extra_r;

  logic [OWNER_W-1:0]  o_start_r;
  logic [OWNER_W-1:0]  o_end_r;
  logic [OWNER_W-1:0]  o_r;

  logic [ROW_BITS-1:0] prod_r;
  logic [ROW_BITS-1:0] bstart_r;
  logic [ROW_BITS-1:0] bnext_r;

  // output register
  logic                out_valid_r;
  owner_t              out_owner_r;
  row_field_t          out_first_r;
  row_field_t          out_last_r;
  logic                out_is_last_r;
  logic                out_empty_r;

  logic [PCOUNT_W-1:0] p_eff;
  logic [PCOUNT_W-1:0] p_min_n;
  logic [OWNER_W-1:0]  cap_calc;
  logic [ROW_BITS-1:0] prep_row;
  logic                prep_below_sw;
  logic [ROW_BITS:0]   owner_cand;
  logic [OWNER_W-1:0]  owner_clamped;
  logic [ROW_BITS+PCOUNT_W:0] sw_prod;
  logic [ROW_BITS+OWNER_W-1:0] base_prod;
  logic [PCOUNT_W-1:0] min_o_extra;
  logic                o_start_small;
  logic                o_next_small;
  logic                out_free;
  logic                out_load;
  logic                in_fire;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  always_comb begin
    if (proc_count_r == '0) begin
      p_eff = PCOUNT_W'(1);
    end else if (proc_count_r > PCOUNT_W'(MAX_OWNERS)) begin
      p_eff = PCOUNT_W'(MAX_OWNERS);
    end else begin
      p_eff = proc_count_r;
    end

    if (total_rows_r < ROW_BITS'(p_eff)) begin
      p_min_n = total_rows_r[PCOUNT_W-1:0];
    end else begin
      p_min_n = p_eff;
    end
    cap_calc = (total_rows_r == '0) ? '0 : OWNER_W'(p_min_n - PCOUNT_W'(1));

    // one restoring division step
    div_trial   = {div_rem_r, div_dvd_r[ROW_BITS-1]};
    div_ge      = (div_trial >= {1'b0, div_dvs_r});
    div_rem_nxt = div_ge ? (ROW_BITS+1)'(div_trial - {1'b0, div_dvs_r})
                         : div_trial[ROW_BITS:0];
    div_q_nxt   = {div_q_r[ROW_BITS-2:0], div_ge};

    prep_row      = which_r ? last_r : first_r;
    prep_below_sw = ({1'b0, prep_row} < sw_r);

    owner_cand = add_extra_r ? ({1'b0, div_q_nxt} + (ROW_BITS+1)'(extra_r))
                             : {1'b0, div_q_nxt};
    owner_clamped = (owner_cand > (ROW_BITS+1)'(cap_r)) ? cap_r
                                                         : owner_cand[OWNER_W-1:0];

    sw_prod   = ({1'b0, size_r} + (ROW_BITS+1)'(1)) * extra_r;
    base_prod = size_r * o_start_r;

    min_o_extra   = (PCOUNT_W'(o_start_r) < extra_r) ? PCOUNT_W'(o_start_r) : extra_r;
    o_start_small = (PCOUNT_W'(o_start_r) < extra_r);
    o_next_small  = ((PCOUNT_W'(o_r) + PCOUNT_W'(1)) < extra_r);

    out_free = !out_valid_r || out_ch.ready;
    out_load = out_free && ((state_r == S_EMIT) || (state_r == S_EMPTY));
    in_fire  = in_ch.valid && in_ch.ready;
  end

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.owner       = out_owner_r;
  assign out_ch.piece_first = out_first_r;
  assign out_ch.piece_last  = out_last_r;
  assign out_ch.is_last     = out_is_last_r;
  assign out_ch.empty_res   = out_empty_r;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_rows_r <= ROW_BITS'(64);
      proc_count_r <= PCOUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TOTAL_ROWS: total_rows_r <= cfg_wdata[ROW_BITS-1:0];
        REG_PROC_COUNT: proc_count_r <= cfg_wdata[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            first_r   <= in_ch.range_first[ROW_BITS-1:0];
            last_r    <= in_ch.range_last[ROW_BITS-1:0];
            div_dvd_r <= total_rows_r;
            div_dvs_r <= (ROW_BITS+1)'(p_eff);
            div_rem_r <= '0;
            div_q_r   <= '0;
            div_cnt_r <= CNT_W'(ROW_BITS);
            if (in_ch.range_first[ROW_BITS-1:0] > in_ch.range_last[ROW_BITS-1:0]) begin
              state_r <= S_EMPTY;
            end else begin
              state_r <= S_DIVN;
            end
          end
        end

        S_DIVN: begin
          div_dvd_r <= {div_dvd_r[ROW_BITS-2:0], 1'b0};
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          div_cnt_r <= div_cnt_r - CNT_W'(1);
          if (div_cnt_r == CNT_W'(1)) begin
            size_r  <= div_q_nxt;
            extra_r <= div_rem_nxt[PCOUNT_W-1:0];   // remainder is below the effective owner count
            state_r <= S_SW;
          end
        end

        S_SW: begin
          // rows below sw belong to the owners holding one extra row
          sw_r    <= sw_prod[ROW_BITS:0];
          cap_r   <= cap_calc;
          which_r <= 1'b0;
          state_r <= S_PREP;
        end

        S_PREP: begin
          div_rem_r <= '0;
          div_q_r   <= '0;
          div_cnt_r <= CNT_W'(ROW_BITS);
          if (prep_below_sw) begin
            div_dvd_r   <= prep_row;
            div_dvs_r   <= {1'b0, size_r} + (ROW_BITS+1)'(1);
            add_extra_r <= 1'b0;
            state_r     <= S_DIVR;
          end else if (size_r == '0) begin
            // no full blocks: the row lies past the distribution
            if (which_r) begin
              o_end_r <= cap_r;
              state_r <= S_BASE1;
            end else begin
              o_start_r <= cap_r;
              which_r   <= 1'b1;
            end
          end else begin
            div_dvd_r   <= ROW_BITS'(({1'b0, prep_row}) - sw_r);
            div_dvs_r   <= {1'b0, size_r};
            add_extra_r <= 1'b1;
            state_r     <= S_DIVR;
          end
        end

        S_DIVR: begin
          div_dvd_r <= {div_dvd_r[ROW_BITS-2:0], 1'b0};
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          div_cnt_r <= div_cnt_r - CNT_W'(1);
          if (div_cnt_r == CNT_W'(1)) begin
            if (which_r) begin
              o_end_r <= owner_clamped;
              state_r <= S_BASE1;
            end else begin
              o_start_r <= owner_clamped;
              which_r   <= 1'b1;
              state_r   <= S_PREP;
            end
          end
        end

        S_BASE1: begin
          prod_r  <= base_prod[ROW_BITS-1:0];
          state_r <= S_BASE2;
        end

        S_BASE2: begin
          bstart_r <= prod_r + ROW_BITS'(min_o_extra);
          state_r  <= S_BASE3;
        end

        S_BASE3: begin
          bnext_r <= bstart_r + size_r + ROW_BITS'(o_start_small);
          o_r     <= o_start_r;
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_owner_r   <= o_r;
            out_first_r   <= (o_r == o_start_r) ? FIELD_W'(first_r) : FIELD_W'(bstart_r);
            out_last_r    <= (o_r == o_end_r) ? FIELD_W'(last_r)
                                              : FIELD_W'(bnext_r - ROW_BITS'(1));
            out_is_last_r <= (o_r == o_end_r);
            out_empty_r   <= 1'b0;
            if (o_r == o_end_r) begin
              state_r <= S_IDLE;
            end else begin
              o_r      <= o_r + OWNER_W'(1);
              bstart_r <= bnext_r;
              bnext_r  <= bnext_r + size_r + ROW_BITS'(o_next_small);
            end
          end
        end

        S_EMPTY: begin
          if (out_free) begin
            out_owner_r   <= '0;
            out_first_r   <= '0;
            out_last_r    <= '0;
            out_is_last_r <= 1'b0;
            out_empty_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/tb_block_partition_range_splitter_top.sv
// ----------------------------------------------------------------------------
// tb_block_partition_range_splitter_top: range splitter testbench
// A table of directed ranges runs first, then random ranges over random
// distributions. Every piece is checked against a local split predictor or
// a written expectation. Both channels stall in random bursts, but for the quiet ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_partition_range_splitter_top;
  import bprs_pkg::*;

  localparam int RANDOM_ITEMS   = 185;
  localparam int QUIET_ITEMS    = 30;     // last random ranges run with no idling
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 200;
  localparam int MAX_REPORTS    = 10;
  localparam logic [30:0] ROW_MAX = 31'h7FFFFFFF;
  localparam logic [30:0] ROW_TOP = 31'd2147483646;

  typedef struct packed {
    owner_t     owner;
    row_field_t row_lo;
    row_field_t row_hi;
    logic       is_last;
    logic       empty_res;
  } piece_t;

  typedef struct {
    logic [30:0] total;
    logic [6:0]  pcount;
    row_field_t  first_row;
    row_field_t  last_row;
    bit          has_want;
    piece_t      want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // reset distribution: one owner of every row
    '{31'd64, 7'd1, 31'd0, 31'd0, 1'b1, '{6'd0, 31'd0, 31'd0, 1'b1, 1'b0}},
    '{31'd64, 7'd1, 31'd3, 31'd40, 1'b1, '{6'd0, 31'd3, 31'd40, 1'b1, 1'b0}},
    '{31'd64, 7'd1, 31'd10, 31'd5, 1'b1, '{6'd0, 31'd0, 31'd0, 1'b0, 1'b1}},
    '{31'd64, 7'd1, ROW_TOP, ROW_TOP, 1'b1, '{6'd0, ROW_TOP, ROW_TOP, 1'b1, 1'b0}},
    '{31'd64, 7'd1, 31'd0, ROW_MAX, 1'b1, '{6'd0, 31'd0, ROW_MAX, 1'b1, 1'b0}},
    '{31'd64, 7'd1, ROW_MAX, 31'd0, 1'b1, '{6'd0, 31'd0, 31'd0, 1'b0, 1'b1}},
    // even split, block boundaries
    '{31'd64, 7'd4, 31'd0, 31'd63, 1'b0, '0},
    '{31'd64, 7'd4, 31'd15, 31'd16, 1'b0, '0},
    '{31'd64, 7'd4, 31'd16, 31'd16, 1'b0, '0},
    // uneven split, first owner holds one extra row
    '{31'd10, 7'd3, 31'd0, 31'd9, 1'b0, '0},
    '{31'd10, 7'd3, 31'd4, 31'd4, 1'b0, '0},
    '{31'd10, 7'd3, 31'd5, 31'd200, 1'b0, '0},
    // more owners than rows
    '{31'd5, 7'd64, 31'd0, 31'd100, 1'b0, '0},
    '{31'd5, 7'd64, 31'd7, 31'd9, 1'b0, '0},
    // no rows at all
    '{31'd0, 7'd8, 31'd0, 31'd5, 1'b0, '0},
    // owner count of zero, and above the maximum
    '{31'd100, 7'd0, 31'd0, 31'd99, 1'b0, '0},
    '{31'd100, 7'd127, 31'd0, 31'd99, 1'b0, '0},
    // widest distribution
    '{ROW_MAX, 7'd64, 31'd0, ROW_TOP, 1'b0, '0},
    '{ROW_MAX, 7'd64, ROW_TOP, ROW_TOP, 1'b0, '0},
    '{ROW_MAX, 7'd64, 31'd1073741823, 31'd1073741824, 1'b0, '0},
    '{ROW_MAX, 7'd64, 31'd7, 31'd3, 1'b1, '{6'd0, 31'd0, 31'd0, 1'b0, 1'b1}},
    '{31'd1, 7'd1, 31'd0, 31'd0, 1'b1, '{6'd0, 31'd0, 31'd0, 1'b1, 1'b0}},
    '{31'd1, 7'd1, 31'd1, 31'd1, 1'b1, '{6'd0, 31'd1, 31'd1, 1'b1, 1'b0}},
    '{31'd128, 7'd64, 31'd1, 31'd2, 1'b0, '0},
    '{31'd128, 7'd64, 31'd0, 31'd127, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bprs_in_if  in_bus ();
  bprs_out_if out_bus ();

  block_partition_range_splitter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // predictor copy of the registers
  logic [30:0] cfg_total;
  logic [6:0]  cfg_pcount;

  piece_t pending_pieces [$];
  int     fail_cnt;
  bit     src_idle_en;
  bit     sink_idle_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // split predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned row_owner(longint unsigned row, longint unsigned n,
                                                longint unsigned p);
    longint unsigned size, extra, wide_end, cap, o;
    size     = n / p;
    extra    = n - size * p;
    wide_end = (size + 1) * extra;
    cap      = (n == 0) ? 0 : ((p < n) ? p : n) - 1;
    if (row < wide_end) begin
      o = row / (size + 1);
    end else if (size == 0) begin
      o = cap;
    end else begin
      o = extra + (row - wide_end) / size;
    end
    return (o > cap) ? cap : o;
  endfunction

  function automatic longint unsigned block_lo(longint unsigned o, longint unsigned n,
                                               longint unsigned p);
    longint unsigned size, extra;
    size  = n / p;
    extra = n - size * p;
    return size * o + ((o < extra) ? o : extra);
  endfunction

  function automatic longint unsigned block_hi(longint unsigned o, longint unsigned n,
                                               longint unsigned p);
    longint unsigned size, extra;
    size  = n / p;
    extra = n - size * p;
    return size * (o + 1) + (((o + 1) < extra) ? (o + 1) : extra) - 1;
  endfunction

  function automatic longint unsigned live_owners();
    longint unsigned p;
    p = cfg_pcount;
    if (p == 0) p = 1;
    if (p > DEF_MAX_OWNERS) p = DEF_MAX_OWNERS;
    return p;
  endfunction

  function automatic void split_range(row_field_t f, row_field_t l);
    longint unsigned n, p, o_lo, o_hi, o;
    piece_t pc;
    n  = cfg_total;
    p  = live_owners();
    pc = '0;
    if (f > l) begin
      pc.empty_res = 1'b1;
      pending_pieces.push_back(pc);
      return;
    end
    o_lo = row_owner(f, n, p);
    o_hi = row_owner(l, n, p);
    for (o = o_lo; o <= o_hi; o++) begin
      pc.owner     = owner_t'(o);
      pc.row_lo    = (o == o_lo) ? f : row_field_t'(block_lo(o, n, p));
      pc.row_hi    = (o == o_hi) ? l : row_field_t'(block_hi(o, n, p));
      pc.is_last   = (o == o_hi);
      pc.empty_res = 1'b0;
      pending_pieces.push_back(pc);
    end
  endfunction

  function automatic string piece_text(piece_t pc);
    return $sformatf("owner=%0d first=%0d last=%0d is_last=%0b empty=%0b",
                     pc.owner, pc.row_lo, pc.row_hi, pc.is_last, pc.empty_res);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // ends at the edge where the request is taken
  task automatic send_range(row_field_t f, row_field_t l);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 2) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.range_first <= f;
    in_bus.range_last  <= l;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pieces.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_TOTAL_ROWS) cfg_total = data[30:0];
    else cfg_pcount = data[6:0];
  endtask

  task automatic set_distribution(logic [30:0] total, logic [6:0] pcount);
    logic [CFG_DATA_W-1:0] pc_word;
    release_input();
    wait_drained();
    // upper bits of the owner count word are junk
    pc_word = {24'($urandom_range(0, 32'h00FF_FFFF)), pcount};
    write_reg(REG_TOTAL_ROWS, total);
    write_reg(REG_PROC_COUNT, pc_word);
  endtask

  function automatic logic [30:0] pick_total();
    case ($urandom_range(0, 9))
      0:       return 31'd1;
      1:       return ROW_MAX;
      2:       return 31'd0;
      3, 4, 5: return 31'($urandom_range(1, 200));
      6, 7:    return 31'($urandom_range(1, 100000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_pcount();
    case ($urandom_range(0, 9))
      0:       return 7'd64;
      1:       return 7'd1;
      2:       return 7'd0;
      3:       return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic pick_range(output row_field_t f, output row_field_t l);
    longint unsigned n, span_max;
    int unsigned     mode;
    n    = cfg_total;
    mode = $urandom_range(0, 19);
    if (mode < 12 && n != 0) begin
      // well-formed range inside the distribution
      f = 31'($urandom_range(0, 32'(n - 1)));
      span_max = n - 1 - f;
      if ($urandom_range(0, 1) == 0) begin
        if (3 * (n / live_owners()) + 2 < span_max) span_max = 3 * (n / live_owners()) + 2;
      end
      l = 31'(f + $urandom_range(0, 32'(span_max)));
    end else if (mode < 15) begin
      // may reach past the last row
      f = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'((n < ROW_MAX) ? n : ROW_MAX);
      l = 31'($urandom_range(32'(f), 32'(ROW_MAX)));
    end else if (mode < 17) begin
      l = 31'($urandom_range(0, 32'(ROW_TOP)));
      f = 31'($urandom_range(32'(l) + 1, 32'(ROW_MAX)));
    end else begin
      f = 31'($urandom);
      l = 31'($urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready bursts and piece checking
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : piece_check
    piece_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.owner, out_bus.piece_first, out_bus.piece_last,
              out_bus.is_last, out_bus.empty_res};
      if (pending_pieces.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("unexpected piece: %s", piece_text(got));
      end else begin
        want = pending_pieces.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("piece mismatch: expected %s", piece_text(want));
            $display("                actual   %s", piece_text(got));
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_field_t f, l;
    int         phase_end;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= REG_TOTAL_ROWS;
    cfg_wdata          <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.range_first <= '0;
    in_bus.range_last  <= '0;
    fail_cnt     = 0;
    cfg_total    = 31'd64;
    cfg_pcount   = 7'd1;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].total != cfg_total || directed_rows[i].pcount != cfg_pcount)
        set_distribution(directed_rows[i].total, directed_rows[i].pcount);
      send_range(directed_rows[i].first_row, directed_rows[i].last_row);
      if (directed_rows[i].has_want) pending_pieces.push_back(directed_rows[i].want);
      else split_range(directed_rows[i].first_row, directed_rows[i].last_row);
    end

    phase_end = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= phase_end) begin
        set_distribution(pick_total(), pick_pcount());
        phase_end    = i + $urandom_range(8, 20);
        src_idle_en  = (i < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
        sink_idle_en = (i < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 15) == 0) begin
        // hold the next request until the current one has fully drained
        release_input();
        wait_drained();
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      pick_range(f, l);
      send_range(f, l);
      split_range(f, l);
    end

    release_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_pieces.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bprs_pkg.sv
hdl/bprs_in_if.sv
hdl/bprs_out_if.sv
hdl/block_partition_range_splitter_top.sv
sim/tb_block_partition_range_splitter_top.sv
